FILE: hw/rtl/keq_pkg.sv
`default_nettype none

package keq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int KEY_COUNT_DEF   = 255;

    // actions
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // event kinds
    localparam logic [1:0] KIND_CURSOR = 2'd0;
    localparam logic [1:0] KIND_KEY    = 2'd1;
    localparam logic [1:0] KIND_BUTTON = 2'd2;
    localparam logic [1:0] KIND_ENTER  = 2'd3;

    // transitions
    localparam logic [1:0] TR_PRESS   = 2'd0;
    localparam logic [1:0] TR_RELEASE = 2'd1;
    localparam logic [1:0] TR_REPEAT  = 2'd2;

    // result status
    localparam logic [2:0] ST_QUEUED    = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_POPPED    = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  code;
        logic [1:0]  trans;
        logic [15:0] scan;
        logic [15:0] x;
        logic [15:0] y;
        logic        enter;
    } t_event;

    localparam int EVENT_W = $bits(t_event);

endpackage

`default_nettype wire

FILE: hw/rtl/keq_ram.sv
`default_nettype none

module keq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/key_event_queue_with_repeat_top.sv
// key event queue with autorepeat
//
// input channel (i_in_valid / o_in_stall): one command per transfer, push,
// pop or clear, with the event fields alongside. output channel
// (o_out_valid / i_out_stall): exactly one result per command, carrying
// a status, the popped event (zero unless popped) and the fill after it.
// config channel (i_cfg_valid / o_cfg_ready): bit 0 of i_cfg_data sets the
// key repeat enable; write it only while no command is in flight.
//
// each command has a transfer cycle, which presents the ring read address
// and the key table address to the synchronous memories, and an execute
// cycle, which uses the read data, writes back and loads the result
// register; no new command is taken until the execute cycle completes. a
// new command may be taken while the last result is still waiting; the
// execute cycle then holds until the output register is free, so a stalled
// receiver backs up into o_in_stall.
//
// after reset the ring is empty, all keys read as released (per-key valid
// bits are cleared at once, no sweep) and key repeat is off.
`default_nettype none

module key_event_queue_with_repeat_top #(
    parameter int QUEUE_DEPTH = keq_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_COUNT   = keq_pkg::KEY_COUNT_DEF,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_action,
    input  wire logic [1:0]         i_event_kind,
    input  wire logic               i_track_state,
    input  wire logic [7:0]         i_code,
    input  wire logic [1:0]         i_transition,
    input  wire logic [15:0]        i_scan_code,
    input  wire logic signed [15:0] i_x_pos,
    input  wire logic signed [15:0] i_y_pos,
    input  wire logic               i_enter_flag,

    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [2:0]              o_status,
    output logic [1:0]              o_out_kind,
    output logic [7:0]              o_out_code,
    output logic [1:0]              o_out_transition,
    output logic [15:0]             o_out_scan_code,
    output logic signed [15:0]      o_out_x,
    output logic signed [15:0]      o_out_y,
    output logic                    o_out_enter,
    output logic [CW-1:0]           o_queue_count,

    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_data
);

    localparam int AW        = $clog2(QUEUE_DEPTH);
    localparam int KW        = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int KEY_SLOTS = 1 << KW;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;

    // latched command
    logic [1:0]  r_action, r_kind, r_trans;
    logic        r_track, r_enter;
    logic [7:0]  r_code;
    logic [15:0] r_scan, r_x, r_y;

    // queue control
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [CW-1:0] r_count, n_count;

    logic r_repeat_en;

    // key table: ram plus a valid bit per key, invalid reads as released
    logic [KEY_SLOTS-1:0] r_key_valid;
    logic [KW-1:0]        key_raddr;
    logic [KW-1:0]        key_idx;
    logic                 key_rdata;
    logic                 key_we;
    logic                 key_wdata;

    // ring store
    keq_pkg::t_event ev_rdata;
    keq_pkg::t_event ev_wdata;
    logic            ev_we;

    // result register
    logic            r_out_valid, n_out_valid;
    logic [2:0]      r_status, n_status;
    keq_pkg::t_event r_out_ev, n_out_ev;

    logic in_xfer, proceed, pressed, code_bad;

    assign in_xfer = i_in_valid && (r_state == S_IDLE);
    assign proceed = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign key_idx = r_code[KW-1:0];
    // address from the port in the transfer cycle, from the latch while held
    assign key_raddr = (r_state == S_IDLE) ? i_code[KW-1:0] : key_idx;
    assign pressed  = r_key_valid[key_idx] && key_rdata;
    assign code_bad = ({1'b0, r_code} >= 9'(KEY_COUNT)) || (r_trans > keq_pkg::TR_RELEASE);

    keq_ram #(
        .WIDTH (keq_pkg::EVENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_event_ram (
        .i_clk   (i_clk),
        .i_we    (ev_we),
        .i_waddr (r_wr_idx),
        .i_wdata (ev_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ev_rdata)
    );

    keq_ram #(
        .WIDTH (1),
        .DEPTH (KEY_COUNT)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_idx),
        .i_wdata (key_wdata),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    always_comb begin
        logic [2:0]      st;
        logic [1:0]      tr;
        keq_pkg::t_event ev;

        n_state     = r_state;
        n_rd_idx    = r_rd_idx;
        n_wr_idx    = r_wr_idx;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_out_ev    = r_out_ev;
        key_we      = 1'b0;
        key_wdata   = 1'b0;
        ev_we       = 1'b0;
        st          = keq_pkg::ST_INVALID;
        tr          = r_trans;
        ev          = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (in_xfer) begin
            n_state = S_EXEC;
        end

        if (proceed) begin
            n_state = S_IDLE;
            case (r_action)
                keq_pkg::ACT_PUSH: begin
                    st      = keq_pkg::ST_QUEUED;
                    ev.kind = r_kind;
                    case (r_kind)
                        keq_pkg::KIND_CURSOR: begin
                            ev.x = r_x;
                            ev.y = r_y;
                        end
                        keq_pkg::KIND_KEY: begin
                            if (code_bad) begin
                                st = keq_pkg::ST_INVALID;
                            end else if (r_track) begin
                                if (r_trans == keq_pkg::TR_PRESS) begin
                                    if (pressed) begin
                                        if (r_repeat_en) begin
                                            tr = keq_pkg::TR_REPEAT;
                                        end else begin
                                            st = keq_pkg::ST_DUPLICATE;
                                        end
                                    end else begin
                                        key_we    = 1'b1;
                                        key_wdata = 1'b1;
                                    end
                                end else begin
                                    if (!pressed) begin
                                        st = keq_pkg::ST_DUPLICATE;
                                    end else begin
                                        key_we    = 1'b1;
                                        key_wdata = 1'b0;
                                    end
                                end
                            end
                            ev.code  = r_code;
                            ev.trans = tr;
                            ev.scan  = r_scan;
                        end
                        keq_pkg::KIND_BUTTON: begin
                            ev.code  = r_code;
                            ev.trans = r_trans;
                            ev.x     = r_x;
                            ev.y     = r_y;
                        end
                        default: begin
                            ev.x     = r_x;
                            ev.y     = r_y;
                            ev.enter = r_enter;
                        end
                    endcase
                    // table is updated even when the ring turns out full
                    if (st == keq_pkg::ST_QUEUED) begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            st = keq_pkg::ST_FULL;
                        end else begin
                            ev_we    = 1'b1;
                            n_wr_idx = (r_wr_idx == AW'(QUEUE_DEPTH - 1)) ? '0
                                     : r_wr_idx + 1'b1;
                            n_count  = r_count + 1'b1;
                        end
                    end
                    n_out_ev = '0;
                end
                keq_pkg::ACT_POP: begin
                    if (r_count == '0) begin
                        st       = keq_pkg::ST_EMPTY;
                        n_out_ev = '0;
                    end else begin
                        st       = keq_pkg::ST_POPPED;
                        n_out_ev = ev_rdata;
                        n_rd_idx = (r_rd_idx == AW'(QUEUE_DEPTH - 1)) ? '0
                                 : r_rd_idx + 1'b1;
                        n_count  = r_count - 1'b1;
                    end
                end
                keq_pkg::ACT_CLEAR: begin
                    st       = keq_pkg::ST_CLEARED;
                    n_rd_idx = '0;
                    n_wr_idx = '0;
                    n_count  = '0;
                    n_out_ev = '0;
                end
                default: begin
                    st       = keq_pkg::ST_INVALID;
                    n_out_ev = '0;
                end
            endcase
            n_status    = st;
            n_out_valid = 1'b1;
        end
        ev_wdata = ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_repeat_en <= 1'b0;
            r_key_valid <= '0;
        end else begin
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_wr_idx    <= n_wr_idx;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_repeat_en <= i_cfg_data;
            end
            if (key_we) begin
                r_key_valid[key_idx] <= 1'b1;
            end
        end
        // result payload, no reset
        r_status <= n_status;
        r_out_ev <= n_out_ev;
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_action <= i_action;
            r_kind   <= i_event_kind;
            r_track  <= i_track_state;
            r_code   <= i_code;
            r_trans  <= i_transition;
            r_scan   <= i_scan_code;
            r_x      <= i_x_pos;
            r_y      <= i_y_pos;
            r_enter  <= i_enter_flag;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_out_kind       = r_out_ev.kind;
    assign o_out_code       = r_out_ev.code;
    assign o_out_transition = r_out_ev.trans;
    assign o_out_scan_code  = r_out_ev.scan;
    assign o_out_x          = $signed(r_out_ev.x);
    assign o_out_y          = $signed(r_out_ev.y);
    assign o_out_enter      = r_out_ev.enter;
    // count register only moves when a result is loaded, so it matches it
    assign o_queue_count    = r_count;

endmodule

`default_nettype wire

FILE: hw/rtl/keq_checker.sv
`default_nettype none

module keq_checker #(
    parameter int QUEUE_DEPTH = keq_pkg::QUEUE_DEPTH_DEF,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire logic [2:0]    o_status,
    input wire logic [1:0]    o_out_kind,
    input wire logic [7:0]    o_out_code,
    input wire logic [CW-1:0] o_queue_count
);

    // a held result keeps its status and fill
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
        && $stable(o_queue_count))
        else $error("held result changed");

    // a command transfer is followed by a busy cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("no execute cycle after transfer");

    // fill agrees with clear and full drop
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != keq_pkg::ST_CLEARED || o_queue_count == '0)
        && (o_status != keq_pkg::ST_FULL || o_queue_count == CW'(QUEUE_DEPTH)))
        else $error("fill inconsistent with status");

    // event kind and code are zero unless popped
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != keq_pkg::ST_POPPED
        |-> o_out_kind == 2'd0 && o_out_code == 8'd0)
        else $error("event fields set without pop");

endmodule

bind key_event_queue_with_repeat_top keq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_keq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_out_kind    (o_out_kind),
    .o_out_code    (o_out_code),
    .o_queue_count (o_queue_count)
);

`default_nettype wire
